// File: rtl/ttsw_pkg.sv
// ----------------------------------------------------------------------------
// ttsw_pkg
// Shared constants and codes for the tick timer and stopwatch unit.
// ----------------------------------------------------------------------------
package ttsw_pkg;

    localparam int WATCH_COUNT = 4;
    localparam int TALLY_BITS  = 20;

    localparam int KIND_BITS  = 3;
    localparam int COUNT_BITS = 15;
    localparam int INDEX_BITS = 2;
    localparam int STAMP_BITS = 8;
    localparam int ELAP_BITS  = 30;

    localparam int RAW_BITS  = TALLY_BITS + STAMP_BITS + 2;
    localparam int WIDE_BITS = (RAW_BITS > ELAP_BITS) ? RAW_BITS : ELAP_BITS;

    localparam int S_DATA_BITS = 32;
    localparam int M_DATA_BITS = 40;

    localparam logic [KIND_BITS-1:0] KIND_TICK         = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_SET_DELAY    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_SET_SWEEP    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_SET_DEBOUNCE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_SET_TIMEOUT  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_START        = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_READ         = 3'd6;

    localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};
    localparam logic [ELAP_BITS-1:0]  ELAP_MAX  = {ELAP_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef logic [TALLY_BITS-1:0] tally_t;
    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [COUNT_BITS-1:0] count_t;

endpackage

// File: rtl/tick_timers_and_stopwatches_unit.sv
// ----------------------------------------------------------------------------
// tick_timers_and_stopwatches_unit
// Four tick-driven down-counters with link timeout, plus a bank of stopwatches.
// ----------------------------------------------------------------------------
// Takes one word per clock while s_tready is high and returns one status word
// per input word, in order. A word passes an input register, then the counter
// and stopwatch update that writes the result register. A waiting result
// holds while m_tready is low, and s_tready drops only when both registers
// are full and m_tready is low. Kinds: tick, set delay, set sweep, set
// debounce, set timeout, start, read; a read returns 4 us per prescaled count
// plus 1024 us per overflow, saturating at the 30-bit maximum.
module tick_timers_and_stopwatches_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // load_value[14:0], watch_index[16:15], counter_now[24:17], restart[25]
    input  logic [31:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // delay_ready[0], sweep_ready[1], debounce_ready[2], link_error[3],
    // timeout_event[4], elapsed_us[34:5]
    output logic [39:0] m_tdata
);
    import ttsw_pkg::*;

    logic                  in_valid_reg;
    logic [KIND_BITS-1:0]  kind_reg;
    count_t                load_reg;
    logic [INDEX_BITS-1:0] index_reg;
    stamp_t                now_reg;
    logic                  restart_reg;

    logic                  out_valid_reg;
    logic [M_DATA_BITS-1:0] out_data_reg;

    count_t delay_reg, delay_next;
    count_t sweep_reg, sweep_next;
    count_t debounce_reg, debounce_next;
    count_t timeout_reg, timeout_next;
    logic   error_reg, error_next;
    stamp_t stamp_reg  [WATCH_COUNT];
    stamp_t stamp_next [WATCH_COUNT];
    tally_t tally_reg  [WATCH_COUNT];
    tally_t tally_next [WATCH_COUNT];
    logic [WATCH_COUNT-1:0] active_reg, active_next;

    logic                   advance;
    logic                   process;
    logic                   event_flag;
    logic [ELAP_BITS-1:0]   elapsed;
    logic [WIDE_BITS-1:0]   wide;
    tally_t                 tally_adj;
    stamp_t                 diff;
    logic                   sel;
    logic [M_DATA_BITS-1:0] result;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        delay_next    = delay_reg;
        sweep_next    = sweep_reg;
        debounce_next = debounce_reg;
        timeout_next  = timeout_reg;
        error_next    = error_reg;
        active_next   = active_reg;
        event_flag    = 1'b0;
        elapsed       = '0;
        wide          = '0;
        tally_adj     = '0;
        diff          = '0;
        sel           = 1'b0;
        for (int i = 0; i < WATCH_COUNT; i++) begin
            stamp_next[i] = stamp_reg[i];
            tally_next[i] = tally_reg[i];
        end
        case (kind_reg)
            KIND_TICK: begin
                if (delay_reg != '0) delay_next = delay_reg - COUNT_ONE;
                if (sweep_reg != '0) sweep_next = sweep_reg - COUNT_ONE;
                if (debounce_reg != '0) debounce_next = debounce_reg - COUNT_ONE;
                if (timeout_reg != '0) begin
                    timeout_next = timeout_reg - COUNT_ONE;
                    if (timeout_reg == COUNT_ONE) begin
                        error_next = 1'b1;
                        event_flag = 1'b1;
                    end
                end
                for (int i = 0; i < WATCH_COUNT; i++) begin
                    if (active_reg[i] && tally_reg[i] != TALLY_MAX) begin
                        tally_next[i] = tally_reg[i] + TALLY_BITS'(1);
                    end
                end
            end
            KIND_SET_DELAY:    delay_next    = load_reg;
            KIND_SET_SWEEP:    sweep_next    = load_reg;
            KIND_SET_DEBOUNCE: debounce_next = load_reg;
            KIND_SET_TIMEOUT: begin
                timeout_next = load_reg;
                error_next   = 1'b0;
            end
            KIND_START: begin
                for (int i = 0; i < WATCH_COUNT; i++) begin
                    if (32'(index_reg) == i) begin
                        stamp_next[i]  = now_reg;
                        tally_next[i]  = '0;
                        active_next[i] = 1'b1;
                    end
                end
            end
            KIND_READ: begin
                for (int i = 0; i < WATCH_COUNT; i++) begin
                    if (32'(index_reg) == i) begin
                        sel       = 1'b1;
                        diff      = now_reg - stamp_reg[i];
                        tally_adj = tally_reg[i];
                        if (now_reg < stamp_reg[i] && tally_reg[i] != '0) begin
                            tally_adj = tally_reg[i] - TALLY_BITS'(1);
                        end
                        if (restart_reg) begin
                            stamp_next[i]  = now_reg;
                            tally_next[i]  = '0;
                            active_next[i] = 1'b1;
                        end else begin
                            tally_next[i]  = tally_adj;
                            active_next[i] = 1'b0;
                        end
                    end
                end
                if (sel) begin
                    wide = WIDE_BITS'({tally_adj, diff, 2'b00});
                    if (wide > WIDE_BITS'(ELAP_MAX)) begin
                        elapsed = ELAP_MAX;
                    end else begin
                        elapsed = wide[ELAP_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase
        result = {5'd0, elapsed, event_flag, error_next,
                  (debounce_next == '0), (sweep_next == '0), (delay_next == '0)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            delay_reg     <= '0;
            sweep_reg     <= '0;
            debounce_reg  <= '0;
            timeout_reg   <= '0;
            error_reg     <= 1'b1;
            active_reg    <= '0;
            for (int i = 0; i < WATCH_COUNT; i++) begin
                stamp_reg[i] <= '0;
                tally_reg[i] <= '0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (process) begin
                delay_reg    <= delay_next;
                sweep_reg    <= sweep_next;
                debounce_reg <= debounce_next;
                timeout_reg  <= timeout_next;
                error_reg    <= error_next;
                active_reg   <= active_next;
                for (int i = 0; i < WATCH_COUNT; i++) begin
                    stamp_reg[i] <= stamp_next[i];
                    tally_reg[i] <= tally_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            kind_reg    <= s_tuser;
            load_reg    <= s_tdata[14:0];
            index_reg   <= s_tdata[16:15];
            now_reg     <= s_tdata[24:17];
            restart_reg <= s_tdata[25];
        end
        if (process) begin
            out_data_reg <= result;
        end
    end

    // timeout event comes with the error flag set
    a_event_sets_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> m_tdata[3])
        else $error("timeout event without link error");

    a_set_timeout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && kind_reg == KIND_SET_TIMEOUT) |=> !error_reg)
        else $error("set timeout did not clear error");

    a_timeout_expire: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && kind_reg == KIND_TICK && timeout_reg == COUNT_ONE)
            |=> (error_reg && timeout_reg == '0))
        else $error("timeout expiry not handled");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with free stage");

endmodule
